/* src/skt_pkg.sv */
// shared types and constants for the sorted key table
`default_nettype none

package skt_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_LOOKUP = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_DUPLICATE = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] key_frame;
      logic [15:0]        entry_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] found_handle;
      logic [5:0]  position;
      logic [6:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic               insert_en;
      logic               remove_en;
      logic signed [31:0] key;
      logic [15:0]        handle;
   } cell_cmd_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cell_flag_type;

endpackage

`default_nettype wire

/* src/skt_cell.sv */
// one table slot: key compare and neighbor shift
`default_nettype none

module skt_cell (
   input  wire logic                 clock,
   input  wire skt_pkg::cell_cmd_type cmd,
   input  wire logic                 cmp_en,
   input  wire logic                 occupied,
   input  wire logic                 lt_prev,
   input  wire logic signed [31:0]   prev_key,
   input  wire logic [15:0]          prev_handle,
   input  wire logic signed [31:0]   next_key,
   input  wire logic [15:0]          next_handle,
   output logic signed [31:0]        key,
   output logic [15:0]               handle,
   output skt_pkg::cell_flag_type    flag
);

   logic signed [31:0]     key_ff;
   logic signed [31:0]     key_in;
   logic [15:0]            handle_ff;
   logic [15:0]            handle_in;
   skt_pkg::cell_flag_type flag_ff;
   skt_pkg::cell_flag_type flag_in;

   always_comb begin
      flag_in = flag_ff;
      if (cmp_en) begin
         flag_in.lt = occupied && (key_ff < cmd.key);
         flag_in.eq = occupied && (key_ff == cmd.key);
      end
   end

   always_comb begin
      key_in    = key_ff;
      handle_in = handle_ff;
      if (cmd.insert_en) begin
         if (!lt_prev) begin
            key_in    = prev_key;
            handle_in = prev_handle;
         end else if (!flag_ff.lt) begin
            key_in    = cmd.key;
            handle_in = cmd.handle;
         end
      end else if (cmd.remove_en) begin
         if (!flag_ff.lt) begin
            key_in    = next_key;
            handle_in = next_handle;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      handle_ff <= handle_in;
      flag_ff   <= flag_in;
   end

   assign key    = key_ff;
   assign handle = handle_ff;
   assign flag   = flag_ff;

endmodule

`default_nettype wire

/* src/sorted_key_table_core.sv */
// sorted key table top level: request control, result forming and the cell row
//
//   channel | ports                  | beat taken when
//   --------+------------------------+----------------------------
//   request | start, busy, req_item  | start high and busy low
//   result  | rsp_strobe, rsp_item   | rsp_strobe high, one cycle
//
// an item has a compare phase, in which every cell compares its key,
// then an exec phase, in which the row shifts and the result is formed
// busy is high only in the compare phase, so a new item can be taken
// during the exec phase; the result appears in the cycle after the shift
// reset clears the entry count; slot contents are undefined until written
// the receiver cannot stall the result
`default_nettype none

module sorted_key_table_core #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire skt_pkg::req_type req_item,
   output logic                  rsp_strobe,
   output skt_pkg::rsp_type      rsp_item
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_CMP  = 2'd1;
   localparam logic [1:0] PH_EXEC = 2'd2;

   logic [1:0]             phase_ff;
   logic [1:0]             phase_in;
   skt_pkg::req_type       req_ff;
   skt_pkg::req_type       req_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   skt_pkg::rsp_type       rsp_ff;
   skt_pkg::rsp_type       rsp_in;
   logic                   strobe_ff;
   logic                   strobe_in;
   logic                   accept;

   skt_pkg::cell_cmd_type  cmd;
   logic signed [31:0]     key_arr [CAPACITY];
   logic [15:0]            handle_arr [CAPACITY];
   skt_pkg::cell_flag_type flag_arr [CAPACITY];
   logic [CAPACITY-1:0]    lt_vec;

   logic                   hit;
   logic [15:0]            hit_handle;
   logic [IDX_W-1:0]       bnd_idx;
   logic                   is_full;
   logic [IDX_W+5:0]       pos_wide;
   logic [CNT_W+6:0]       cnt_wide;

   assign busy   = (phase_ff == PH_CMP);
   assign accept = start && !busy;

   always_comb begin
      phase_in = PH_IDLE;
      if (accept) begin
         phase_in = PH_CMP;
      end else if (phase_ff == PH_CMP) begin
         phase_in = PH_EXEC;
      end
   end

   assign req_in = accept ? req_item : req_ff;

   always_comb begin
      hit        = 1'b0;
      hit_handle = '0;
      bnd_idx    = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         lt_vec[i] = flag_arr[i].lt;
         if (flag_arr[i].eq) begin
            hit        = 1'b1;
            hit_handle = hit_handle | handle_arr[i];
         end
         if (!flag_arr[i].lt && ((i == 0) || flag_arr[(i == 0) ? 0 : i - 1].lt)) begin
            bnd_idx = bnd_idx | IDX_W'(i);
         end
      end
   end

   assign is_full = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      cmd.insert_en = 1'b0;
      cmd.remove_en = 1'b0;
      cmd.key       = req_ff.key_frame;
      cmd.handle    = req_ff.entry_handle;
      count_in      = count_ff;
      rsp_in        = rsp_ff;
      strobe_in     = 1'b0;
      pos_wide      = '0;
      if (phase_ff == PH_EXEC) begin
         strobe_in           = 1'b1;
         rsp_in.found_handle = '0;
         rsp_in.status       = skt_pkg::ST_OK;
         if (req_ff.action == skt_pkg::ACT_INSERT) begin
            if (hit) begin
               rsp_in.status = skt_pkg::ST_DUPLICATE;
               pos_wide      = {6'd0, bnd_idx};
            end else if (is_full) begin
               rsp_in.status = skt_pkg::ST_FULL;
            end else begin
               cmd.insert_en = 1'b1;
               count_in      = count_ff + 1'b1;
               pos_wide      = {6'd0, bnd_idx};
            end
         end else if (!hit) begin
            rsp_in.status = skt_pkg::ST_NOT_FOUND;
         end else begin
            rsp_in.found_handle = hit_handle;
            pos_wide            = {6'd0, bnd_idx};
            if (req_ff.action == skt_pkg::ACT_REMOVE) begin
               cmd.remove_en = 1'b1;
               count_in      = count_ff - 1'b1;
            end
         end
         rsp_in.position    = pos_wide[5:0];
         rsp_in.entry_count = cnt_wide[6:0];
      end
   end

   assign cnt_wide = {7'd0, count_in};

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic                occ;
      logic                lt_p;
      logic signed [31:0]  pk;
      logic [15:0]         ph;
      logic signed [31:0]  nk;
      logic [15:0]         nh;

      assign occ = (count_ff > CNT_W'(g));

      if (g == 0) begin : g_first
         assign lt_p = 1'b1;
         assign pk   = key_arr[g];
         assign ph   = handle_arr[g];
      end else begin : g_mid
         assign lt_p = lt_vec[g-1];
         assign pk   = key_arr[g-1];
         assign ph   = handle_arr[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign nk = key_arr[g];
         assign nh = handle_arr[g];
      end else begin : g_inner
         assign nk = key_arr[g+1];
         assign nh = handle_arr[g+1];
      end

      skt_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cmp_en      (phase_ff == PH_CMP),
         .occupied    (occ),
         .lt_prev     (lt_p),
         .prev_key    (pk),
         .prev_handle (ph),
         .next_key    (nk),
         .next_handle (nh),
         .key         (key_arr[g]),
         .handle      (handle_arr[g]),
         .flag        (flag_arr[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

/* bench/tb_sorted_key_table_core.sv */
// self-checking testbench for the sorted key table core
`default_nettype none

module tb_sorted_key_table_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = skt_pkg::CAPACITY_DEFAULT;
   localparam logic [1:0] ACT_SPARE = 2'd3;
   localparam int POOL_SIZE = 96;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   skt_pkg::req_type req_item = '0;
   logic             rsp_strobe;
   skt_pkg::rsp_type rsp_item;

   sorted_key_table_core #(.CAPACITY(CAPACITY)) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #6 clock = ~clock;

   skt_pkg::req_type   pending_requests[$];
   skt_pkg::rsp_type   table_results[$];
   logic signed [31:0] table_keys[CAPACITY];
   logic [15:0]        table_handles[CAPACITY];
   int                 table_count = 0;
   int                 peak_count = 0;
   logic signed [31:0] key_pool[POOL_SIZE];
   int                 sender_idle_pct = 0;
   logic               beat_taken = 1'b0;
   int                 error_count = 0;
   int                 requests_taken = 0;
   int                 results_checked = 0;
   int                 status_seen[4] = '{0, 0, 0, 0};

   function automatic skt_pkg::rsp_type apply_table_request(skt_pkg::req_type r);
      skt_pkg::rsp_type res;
      int               idx;
      int               i;
      bit               hit;
      res = '0;
      idx = 0;
      while (idx < table_count && table_keys[idx] < r.key_frame) idx++;
      hit = (idx < table_count) && (table_keys[idx] == r.key_frame);
      if (r.action == skt_pkg::ACT_INSERT) begin
         if (hit) begin
            res.status = skt_pkg::ST_DUPLICATE;
            res.position = 6'(idx);
         end else if (table_count >= CAPACITY) begin
            res.status = skt_pkg::ST_FULL;
         end else begin
            for (i = table_count; i > idx; i--) begin
               table_keys[i] = table_keys[i - 1];
               table_handles[i] = table_handles[i - 1];
            end
            table_keys[idx] = r.key_frame;
            table_handles[idx] = r.entry_handle;
            table_count++;
            res.status = skt_pkg::ST_OK;
            res.position = 6'(idx);
         end
      end else if (!hit) begin
         res.status = skt_pkg::ST_NOT_FOUND;
      end else begin
         res.status = skt_pkg::ST_OK;
         res.position = 6'(idx);
         res.found_handle = table_handles[idx];
         if (r.action == skt_pkg::ACT_REMOVE) begin
            for (i = idx; i + 1 < table_count; i++) begin
               table_keys[i] = table_keys[i + 1];
               table_handles[i] = table_handles[i + 1];
            end
            table_count--;
         end
      end
      res.entry_count = 7'(table_count);
      if (table_count > peak_count) peak_count = table_count;
      status_seen[res.status]++;
      return res;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // driver: a beat is held until taken, then the next one or an idle cycle
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_item <= pending_requests.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: results against the oldest prediction, accepted beats into the predictor
   always @(posedge clock) begin
      if (reset) begin
         beat_taken <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (table_results.size() == 0) begin
               error_count++;
               $display("%0t: result with none expected, expected nothing, actual %0h",
                        $time, rsp_item);
            end else begin
               check_field("status", table_results[0].status, rsp_item.status);
               check_field("found_handle", table_results[0].found_handle,
                           rsp_item.found_handle);
               check_field("position", table_results[0].position, rsp_item.position);
               check_field("entry_count", table_results[0].entry_count,
                           rsp_item.entry_count);
               void'(table_results.pop_front());
               results_checked++;
            end
         end
         beat_taken <= start && !busy;
         if (start && !busy) begin
            table_results.push_back(apply_table_request(req_item));
            requests_taken++;
         end
      end
   end

   function automatic skt_pkg::req_type make_request(logic [1:0] action,
                                                     logic signed [31:0] key,
                                                     logic [15:0] handle);
      skt_pkg::req_type r;
      r.action = action;
      r.key_frame = key;
      r.entry_handle = handle;
      return r;
   endfunction

   function automatic skt_pkg::req_type random_request(int ins_pct, int rem_pct);
      int         pick;
      int         key_pick;
      logic [1:0] action;
      logic [31:0] key;
      pick = $urandom_range(99);
      if (pick < ins_pct) action = skt_pkg::ACT_INSERT;
      else if (pick < ins_pct + rem_pct) action = skt_pkg::ACT_REMOVE;
      else action = ($urandom_range(3) == 0) ? ACT_SPARE : skt_pkg::ACT_LOOKUP;
      key_pick = $urandom_range(99);
      if (key_pick < 85) key = key_pool[$urandom_range(POOL_SIZE - 1)];
      else if (key_pick < 95) key = $urandom;
      else key = key_pool[$urandom_range(3)];
      return make_request(action, key, 16'($urandom_range(65535)));
   endfunction

   task automatic wait_drained();
      while (pending_requests.size() != 0 || start || table_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(int count, int idle_pct, int ins_pct, int rem_pct);
      int n;
      sender_idle_pct = idle_pct;
      for (n = 0; n < count; n++) pending_requests.push_back(random_request(ins_pct, rem_pct));
      wait_drained();
   endtask

   initial begin
      #5ms;
      $display("sorted_key_table_core test failed");
      $finish;
   end

   initial begin
      int n;
      int settle;
      key_pool[0] = 32'sh8000_0000;
      key_pool[1] = 32'sh7fff_ffff;
      key_pool[2] = 32'sh0000_0000;
      key_pool[3] = -32'sd1;
      for (n = 4; n < POOL_SIZE; n++) begin
         if (n < 24) key_pool[n] = $signed(32'($urandom_range(40))) - 32'sd20;
         else key_pool[n] = $urandom;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // edge keys, each action, duplicate and miss cases, spare action code
      sender_idle_pct = 0;
      pending_requests.push_back(make_request(skt_pkg::ACT_LOOKUP, 32'sd0, 16'h1111));
      pending_requests.push_back(make_request(skt_pkg::ACT_REMOVE, 32'sh8000_0000, 16'h2222));
      pending_requests.push_back(make_request(skt_pkg::ACT_INSERT, 32'sh7fff_ffff, 16'hffff));
      pending_requests.push_back(make_request(skt_pkg::ACT_INSERT, 32'sh8000_0000, 16'h0000));
      pending_requests.push_back(make_request(skt_pkg::ACT_INSERT, 32'sd0, 16'haaaa));
      pending_requests.push_back(make_request(skt_pkg::ACT_INSERT, -32'sd1, 16'h5555));
      pending_requests.push_back(make_request(skt_pkg::ACT_INSERT, 32'sd1, 16'h1234));
      pending_requests.push_back(make_request(skt_pkg::ACT_INSERT, 32'sh7fff_ffff, 16'h0f0f));
      pending_requests.push_back(make_request(skt_pkg::ACT_LOOKUP, 32'sh8000_0000, 16'hffff));
      pending_requests.push_back(make_request(ACT_SPARE, 32'sh7fff_ffff, 16'h0000));
      pending_requests.push_back(make_request(skt_pkg::ACT_LOOKUP, -32'sd1, 16'h0000));
      pending_requests.push_back(make_request(skt_pkg::ACT_REMOVE, 32'sd0, 16'h0000));
      pending_requests.push_back(make_request(skt_pkg::ACT_LOOKUP, 32'sd0, 16'h0000));
      pending_requests.push_back(make_request(skt_pkg::ACT_REMOVE, 32'sh7fff_ffff, 16'h0000));
      pending_requests.push_back(make_request(skt_pkg::ACT_REMOVE, 32'sh8000_0000, 16'h0000));
      pending_requests.push_back(make_request(skt_pkg::ACT_INSERT, 32'sh4000_0000, 16'h8001));
      pending_requests.push_back(make_request(skt_pkg::ACT_INSERT, 32'shc000_0000, 16'h7ffe));
      pending_requests.push_back(make_request(ACT_SPARE, 32'sd12345, 16'h0000));
      pending_requests.push_back(make_request(skt_pkg::ACT_REMOVE, 32'sd12345, 16'h0000));
      pending_requests.push_back(make_request(skt_pkg::ACT_INSERT, 32'sd2, 16'hffff));
      wait_drained();

      run_phase(200, 0, 85, 5);
      run_phase(180, 87, 40, 30);
      run_phase(200, 11, 10, 70);
      run_phase(150, 0, 50, 40);
      run_phase(220, 87, 90, 5);
      run_phase(180, 11, 30, 30);
      run_phase(200, 0, 20, 75);
      run_phase(150, 11, 45, 45);

      settle = 0;
      while (table_results.size() != 0 && settle < 1000) begin
         @(posedge clock);
         settle++;
      end
      repeat (8) @(posedge clock);
      if (table_results.size() != 0) begin
         error_count++;
         $display("%0t: %0d results never arrived", $time, table_results.size());
      end

      $display("covered %0d requests: %0d ok, %0d not found, %0d duplicate, %0d table full",
               requests_taken, status_seen[skt_pkg::ST_OK], status_seen[skt_pkg::ST_NOT_FOUND],
               status_seen[skt_pkg::ST_DUPLICATE], status_seen[skt_pkg::ST_FULL]);
      $display("table fill reached %0d of %0d slots, %0d results checked",
               peak_count, CAPACITY, results_checked);
      if (error_count == 0) begin
         $display("sorted_key_table_core test passed");
      end else begin
         $display("sorted_key_table_core test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
src/skt_pkg.sv
src/skt_cell.sv
src/sorted_key_table_core.sv
bench/tb_sorted_key_table_core.sv
